FILE: design/ptptc_pkg.sv
// ----------------------------------------------------------------------------
// ptptc_pkg
// Shared types and constants of the transparent clock pending match table.
// ----------------------------------------------------------------------------
package ptptc_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int PORT_BITS   = 8;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam logic [31:0] ONE_SECOND_NS = 32'd1000000000;

  typedef enum logic [2:0] {
    CMD_SYNC  = 3'd0,
    CMD_FUP   = 3'd1,
    CMD_DREQ  = 3'd2,
    CMD_DRESP = 3'd3,
    CMD_PRUNE = 3'd4,
    CMD_FLUSH = 3'd5
  } cmd_t;

  localparam logic [1:0] KIND_SYNC = 2'd0;
  localparam logic [1:0] KIND_FUP  = 2'd1;
  localparam logic [1:0] KIND_DREQ = 2'd2;

  localparam logic [1:0] RES_FUP_FWD   = 2'd0;
  localparam logic [1:0] RES_DRESP_FWD = 2'd1;
  localparam logic [1:0] RES_STORED    = 2'd2;
  localparam logic [1:0] RES_FULL      = 2'd3;

  // One queued command, as the front part hands it to the back part.
  typedef struct packed {
    logic [2:0]           cmd;
    logic [PORT_BITS-1:0] port;
    logic [15:0]          seq;
    logic [63:0]          clock;
    logic [15:0]          sport;
    logic [63:0]          corr;
    logic [47:0]          res;
    logic [63:0]          extra;  // link delay plus asymmetry, already summed
    logic [62:0]          now;
  } job_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_PRUNE,
    ST_SUM,
    ST_OUT
  } state_t;

endpackage

FILE: design/ptp_tc_pending_match_table_top.sv
// ----------------------------------------------------------------------------
// ptp_tc_pending_match_table_top
// Pending Sync, Follow Up and Delay Req table of one egress port of a
// two-step transparent clock, with residence correction.
// ----------------------------------------------------------------------------
// A word on the input channel is queued in a two-word front queue and then
// handled by the table engine one word at a time. The engine scans the
// table one slot per cycle from the oldest entry; on a match it closes the
// gap one slot per cycle from the matching slot onward, so scan and shift
// together cover the used slots once. A matched word has its new correction
// summed in the sum state before its result goes to the output register,
// where an output stall holds it. Prune drops aged entries from the oldest
// end; flush empties the table. A result sits in the output register until
// taken, while the front queue accepts words until its two entries are full.
// The age limit register is to be written on its own channel only while
// idle; the block itself does not enforce this. Its reset value is one second.
module ptp_tc_pending_match_table_top
  import ptptc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  cmd,
  input  logic [7:0]  port_num,
  input  logic [15:0] seq_id,
  input  logic [63:0] src_clock_id,
  input  logic [15:0] src_port_num,
  input  logic signed [63:0] correction,
  input  logic [47:0] residence,
  input  logic [39:0] link_delay,
  input  logic signed [40:0] asymmetry,
  input  logic [62:0] now_ns,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  result_kind,
  output logic [15:0] out_seq_id,
  output logic signed [63:0] new_correction
);

  logic [31:0] age_limit;
  logic        job_valid, job_take;
  job_t        job;

  // The register takes a write in any cycle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      age_limit <= ONE_SECOND_NS;
    end else if (cfg_valid) begin
      age_limit <= cfg_data;
    end
  end

  ptptc_front u_front (
    .clk, .rst, .in_valid, .in_stall, .cmd, .port_num, .seq_id, .src_clock_id,
    .src_port_num, .correction, .residence, .link_delay, .asymmetry, .now_ns,
    .job_valid, .job, .job_take
  );

  ptptc_engine u_engine (
    .clk, .rst, .age_limit, .job_valid, .job, .job_take, .out_valid,
    .out_stall, .result_kind, .out_seq_id, .new_correction
  );

endmodule

FILE: design/ptptc_front.sv
// ----------------------------------------------------------------------------
// ptptc_front
// Accepts input words, drops unused commands, presums link delay and
// asymmetry, and queues the command for the table engine.
// ----------------------------------------------------------------------------
module ptptc_front
  import ptptc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  cmd,
  input  logic [7:0]  port_num,
  input  logic [15:0] seq_id,
  input  logic [63:0] src_clock_id,
  input  logic [15:0] src_port_num,
  input  logic signed [63:0] correction,
  input  logic [47:0] residence,
  input  logic [39:0] link_delay,
  input  logic signed [40:0] asymmetry,
  input  logic [62:0] now_ns,
  output logic        job_valid,
  output job_t        job,
  input  logic        job_take
);

  // Two-entry queue.
  job_t       q [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       push;
  job_t       nj;

  assign in_stall  = (count == 2'd2);
  assign push      = in_valid && !in_stall && (cmd <= CMD_FLUSH);
  assign job_valid = (count != 2'd0);
  assign job       = q[rd_ptr];

  always_comb begin
    nj.cmd   = cmd;
    nj.port  = port_num[PORT_BITS-1:0];
    nj.seq   = seq_id;
    nj.clock = src_clock_id;
    nj.sport = src_port_num;
    nj.corr  = correction;
    nj.res   = residence;
    nj.extra = {24'd0, link_delay} + {{23{asymmetry[40]}}, asymmetry};
    nj.now   = now_ns;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= nj;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (job_take) rd_ptr <= !rd_ptr;
      count <= count + {1'b0, push} - {1'b0, job_take};
    end
  end

  assert property (@(posedge clk) disable iff (rst) job_take |-> job_valid)
    else $error("queue read while empty");
  assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("queue count out of range");
  assert property (@(posedge clk) disable iff (rst)
    (count == 2'd2 && !job_take) |=> count == 2'd2)
    else $error("full queue lost a word");

endmodule

FILE: design/ptptc_engine.sv
// ----------------------------------------------------------------------------
// ptptc_engine
// Table engine: scans the pending table one slot a cycle, closes gaps one
// slot a cycle, prunes from the oldest end and drives the output register.
// ----------------------------------------------------------------------------
module ptptc_engine
  import ptptc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic [31:0] age_limit,
  input  logic        job_valid,
  input  job_t        job,
  output logic        job_take,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  result_kind,
  output logic [15:0] out_seq_id,
  output logic signed [63:0] new_correction
);

  logic [1:0]           s_kind  [TABLE_DEPTH];
  logic [PORT_BITS-1:0] s_port  [TABLE_DEPTH];
  logic [15:0]          s_seq   [TABLE_DEPTH];
  logic [63:0]          s_clock [TABLE_DEPTH];
  logic [15:0]          s_sport [TABLE_DEPTH];
  logic [63:0]          s_corr  [TABLE_DEPTH];
  logic [47:0]          s_res   [TABLE_DEPTH];
  logic [62:0]          s_stamp [TABLE_DEPTH];

  state_t state, state_next;
  job_t   cur;
  logic [CNT_W-1:0] used;
  logic [CNT_W-1:0] ptr;
  logic [IDX_W-1:0] pidx;
  logic [63:0] acc;
  logic [63:0] addend;
  logic [1:0]  okind;
  logic        hit, scan_end, shift_end, prune_stop;
  logic [62:0] age;

  assign pidx      = ptr[IDX_W-1:0];
  assign scan_end  = (ptr >= used);
  assign shift_end = (ptr + 1'b1 >= used);
  assign age       = cur.now - s_stamp[0];
  assign prune_stop = (used == '0) || (cur.now < s_stamp[0]) ||
                      (age < {31'd0, age_limit});

  always_comb begin
    hit = 1'b0;
    if (!scan_end && s_port[pidx] == cur.port && s_seq[pidx] == cur.seq &&
        s_clock[pidx] == cur.clock && s_sport[pidx] == cur.sport) begin
      hit = (cur.cmd == CMD_FUP   && s_kind[pidx] == KIND_SYNC) ||
            (cur.cmd == CMD_SYNC  && s_kind[pidx] == KIND_FUP) ||
            (cur.cmd == CMD_DRESP && s_kind[pidx] == KIND_DREQ);
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (job_valid) begin
          priority if (job.cmd == CMD_PRUNE) state_next = ST_PRUNE;
          else if (job.cmd == CMD_FLUSH) state_next = ST_IDLE;
          else state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        priority if (hit) state_next = shift_end ? ST_SUM : ST_SHIFT;
        else if (scan_end) state_next = (cur.cmd == CMD_DRESP) ? ST_IDLE : ST_OUT;
      end
      ST_SHIFT: if (shift_end) state_next = ST_SUM;
      ST_PRUNE: if (prune_stop) state_next = ST_IDLE;
      ST_SUM:   state_next = ST_OUT;
      ST_OUT:   if (!out_stall) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    job_take  = (state == ST_IDLE) && job_valid;
    out_valid = (state == ST_OUT);
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        cur <= job;
        ptr <= '0;
      end
      ST_SCAN: begin
        if (hit) begin
          okind <= (cur.cmd == CMD_DRESP) ? RES_DRESP_FWD : RES_FUP_FWD;
          if (cur.cmd == CMD_SYNC) begin
            acc    <= s_corr[pidx];
            addend <= {16'd0, cur.res} + cur.extra;
          end else if (cur.cmd == CMD_FUP) begin
            acc    <= cur.corr;
            addend <= {16'd0, s_res[pidx]} + cur.extra;
          end else begin
            acc    <= cur.corr;
            addend <= {16'd0, s_res[pidx]};
          end
        end else if (scan_end) begin
          acc    <= '0;
          addend <= '0;
          if (used == CNT_W'(TABLE_DEPTH)) begin
            okind <= RES_FULL;
          end else begin
            okind <= RES_STORED;
            s_kind[pidx]  <= cur.cmd[1:0];
            s_port[pidx]  <= cur.port;
            s_seq[pidx]   <= cur.seq;
            s_clock[pidx] <= cur.clock;
            s_sport[pidx] <= cur.sport;
            s_corr[pidx]  <= cur.corr;
            s_res[pidx]   <= cur.res;
            s_stamp[pidx] <= cur.now;
          end
        end else begin
          ptr <= ptr + 1'b1;
        end
      end
      ST_SHIFT: begin
        s_kind[pidx]  <= s_kind[pidx+1'b1];
        s_port[pidx]  <= s_port[pidx+1'b1];
        s_seq[pidx]   <= s_seq[pidx+1'b1];
        s_clock[pidx] <= s_clock[pidx+1'b1];
        s_sport[pidx] <= s_sport[pidx+1'b1];
        s_corr[pidx]  <= s_corr[pidx+1'b1];
        s_res[pidx]   <= s_res[pidx+1'b1];
        s_stamp[pidx] <= s_stamp[pidx+1'b1];
        ptr <= ptr + 1'b1;
      end
      ST_PRUNE: begin
        // Drop the head by shifting every slot down one place.
        if (!prune_stop) begin
          for (int i = 0; i + 1 < TABLE_DEPTH; i++) begin
            s_kind[i]  <= s_kind[i+1];
            s_port[i]  <= s_port[i+1];
            s_seq[i]   <= s_seq[i+1];
            s_clock[i] <= s_clock[i+1];
            s_sport[i] <= s_sport[i+1];
            s_corr[i]  <= s_corr[i+1];
            s_res[i]   <= s_res[i+1];
            s_stamp[i] <= s_stamp[i+1];
          end
        end
      end
      ST_SUM: acc <= acc + addend;
      ST_OUT: ;
      default: ;
    endcase
  end

  assign result_kind    = okind;
  assign out_seq_id     = cur.seq;
  assign new_correction = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      used  <= '0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE && job_valid && job.cmd == CMD_FLUSH) used <= '0;
      if (state == ST_SCAN && hit) used <= used - 1'b1;
      if (state == ST_SCAN && !hit && scan_end && cur.cmd != CMD_DRESP &&
          used != CNT_W'(TABLE_DEPTH)) used <= used + 1'b1;
      if (state == ST_PRUNE && !prune_stop) used <= used - 1'b1;
    end
  end

  assert property (@(posedge clk) disable iff (rst) used <= CNT_W'(TABLE_DEPTH))
    else $error("fill count exceeds table depth");
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT && out_stall) |=> state == ST_OUT)
    else $error("stalled result dropped");
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT && okind == RES_FULL) |-> used == CNT_W'(TABLE_DEPTH))
    else $error("full fault with free slots");

endmodule
